@@ src/dwc_pkg.sv @@
`default_nettype none
package dwc_pkg;

	localparam int MAX_WIDTH   = 1024;
	localparam int MAX_HEIGHT  = 1024;
	localparam int COL_W       = $clog2(MAX_WIDTH);
	localparam int ROW_W       = $clog2(MAX_HEIGHT);
	localparam int DIM_W       = 11;
	localparam int PIX_W       = 16;
	localparam int TAP_COUNT   = 9;
	localparam int ROWTAP_W    = 48;
	localparam int MULT_W      = 24;
	localparam int SHIFT_W     = 6;
	localparam int VAL_W       = 48;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 48;
	localparam int QUEUE_DEPTH = 4;

	localparam logic [CFG_IDX_W-1:0] REG_TAPS_TOP    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TAPS_MIDDLE = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TAPS_BOTTOM = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SCALE_MULT  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SCALE_SHIFT = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_BIAS        = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_WIDTH       = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT      = 3'd7;

	// One queued pixel: the window after the update and which outputs it completes.
	typedef struct packed {
		logic [TAP_COUNT-1:0][PIX_W-1:0] win;
		logic [ROW_W-1:0]                row;
		logic [COL_W-1:0]                col;
		logic                            up;
		logic                            last_row;
		logic                            left;
		logic                            last_col;
	} job_t;

	typedef struct packed {
		logic [2:0][ROWTAP_W-1:0] taps;
		logic [MULT_W-1:0]        mult;
		logic [SHIFT_W-1:0]       shift;
		logic [VAL_W-1:0]         bias;
	} coef_t;

endpackage
`default_nettype wire

@@ src/dwc_ram.sv @@
`default_nettype none
module dwc_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

@@ src/dwc_front.sv @@
`default_nettype none
module dwc_front
	import dwc_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic [COL_W-1:0] wm1,
	input  wire logic [ROW_W-1:0] hm1,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire logic [PIX_W-1:0] pixel,
	output logic                  push,
	output job_t                  push_job,
	input  wire logic             q_full
);

	typedef enum logic [2:0] {
		S_CLEAR = 3'b001,
		S_IDLE  = 3'b010,
		S_UPD   = 3'b100
	} fstate_t;

	fstate_t                         state_q;
	logic [COL_W-1:0]                clr_q;
	logic [ROW_W-1:0]                row_q, i_q, cur_i;
	logic [COL_W-1:0]                col_q, j_q, cur_j;
	logic [PIX_W-1:0]                px_q, older_rd, newer_rd;
	logic [TAP_COUNT-1:0][PIX_W-1:0] win_q, win_nxt;
	logic                            restart, need_push, go;
	logic                            up, last_row, left, last_col;
	logic                            clearing, ram_we;
	logic [COL_W-1:0]                ram_waddr;
	logic [PIX_W-1:0]                older_wd, newer_wd;

	// A plane size shrunk under the current position restarts at the origin.
	assign restart = (col_q > wm1) || (row_q > hm1);
	assign cur_i   = restart ? '0 : row_q;
	assign cur_j   = restart ? '0 : col_q;

	assign in_ready = (state_q == S_IDLE);

	// After reset both line stores are swept to zero, one entry per cycle.
	assign clearing  = (state_q == S_CLEAR);
	assign ram_we    = go || clearing;
	assign ram_waddr = clearing ? clr_q : j_q;
	assign older_wd  = clearing ? '0 : newer_rd;
	assign newer_wd  = clearing ? '0 : px_q;

	dwc_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_older (
		.clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(older_wd),
		.raddr(cur_j), .rdata(older_rd)
	);

	dwc_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_newer (
		.clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(newer_wd),
		.raddr(cur_j), .rdata(newer_rd)
	);

	assign up       = (i_q != '0);
	assign last_row = (i_q == hm1);
	assign left     = (j_q != '0);
	assign last_col = (j_q == wm1);

	assign need_push = (up || last_row) && (left || last_col);
	assign go        = (state_q == S_UPD) && (!need_push || !q_full);
	assign push      = go && need_push;

	always_comb begin
		for (int m = 0; m < 3; m++) begin
			win_nxt[m*3]   = win_q[m*3+1];
			win_nxt[m*3+1] = win_q[m*3+2];
		end
		win_nxt[2] = older_rd;
		win_nxt[5] = newer_rd;
		win_nxt[8] = px_q;
	end

	assign push_job = '{win: win_nxt, row: i_q, col: j_q, up: up,
		last_row: last_row, left: left, last_col: last_col};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q   <= '0;
			row_q   <= '0;
			col_q   <= '0;
			win_q   <= '0;
		end else begin
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == COL_W'(MAX_WIDTH - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_UPD;
					end
				end
				S_UPD: begin
					if (go) begin
						state_q <= S_IDLE;
						win_q   <= win_nxt;
						if (last_col) begin
							col_q <= '0;
							row_q <= last_row ? '0 : i_q + 1'b1;
						end else begin
							col_q <= j_q + 1'b1;
							row_q <= i_q;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			px_q <= pixel;
			i_q  <= cur_i;
			j_q  <= cur_j;
		end
	end

endmodule
`default_nettype wire

@@ src/dwc_queue.sv @@
`default_nettype none
module dwc_queue
	import dwc_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  job_t      push_job,
	output logic      full,
	input  wire logic pop,
	output logic      not_empty,
	output job_t      head
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);

	job_t               slot_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]   wr_q, rd_q;
	logic [PTR_W:0]     count_q;

	assign full      = (count_q == QUEUE_DEPTH[PTR_W:0]);
	assign not_empty = (count_q != '0);
	assign head      = slot_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= push_job;
		end
	end

`ifndef ASSERT_OFF
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full)) else $error("queue written while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && !not_empty)) else $error("queue read while empty");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QUEUE_DEPTH[PTR_W:0]) else $error("queue count out of range");
`endif

endmodule
`default_nettype wire

@@ src/dwc_back.sv @@
`default_nettype none
module dwc_back
	import dwc_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  coef_t                 coef,
	input  wire logic             q_valid,
	input  job_t                  job,
	output logic                  pop,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output logic [VAL_W-1:0]      value,
	output logic [ROW_W-1:0]      out_row,
	output logic [COL_W-1:0]      out_col,
	output logic                  last_in_run,
	output logic                  plane_done
);

	localparam int PROD_W = 2 * PIX_W;
	localparam int ACC_W  = PROD_W + 4;
	localparam int HALF_W = MULT_W / 2;
	localparam int PP_W   = ACC_W + HALF_W + 1;
	localparam int FULL_W = ACC_W + MULT_W + 1;
	localparam int SUM_W  = FULL_W + 1;

	typedef struct packed {
		logic             valid;
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] col;
		logic             last;
		logic             done;
	} meta_t;

	logic                   adv, issue;
	logic                   ra_q, cb_q, rsel, csel, last_r, last_c;
	logic                   r_zero, c_zero;
	meta_t                  meta_in, meta_s1, meta_s2, meta_s3, meta_s4;
	logic signed [PROD_W-1:0] prod_s1 [TAP_COUNT];
	logic signed [ACC_W-1:0]  acc_s2, acc_sum;
	logic signed [PP_W-1:0]   pp_lo_s3, pp_hi_s3;
	logic signed [FULL_W-1:0] full_s4;
	logic signed [FULL_W-1:0] shifted;
	logic signed [SUM_W-1:0]  biased;
	logic [VAL_W-1:0]         sat;

	// The whole pipe moves whenever the output register is free or being emptied.
	assign adv   = !out_valid || out_ready;
	assign issue = adv && q_valid;

	assign rsel   = job.up   ? ra_q : 1'b1;
	assign csel   = job.left ? cb_q : 1'b1;
	assign last_r = (job.up && job.last_row) ? ra_q : 1'b1;
	assign last_c = (job.left && job.last_col) ? cb_q : 1'b1;
	assign pop    = issue && last_r && last_c;

	assign r_zero = rsel ? (job.row == '0) : (job.row == ROW_W'(1));
	assign c_zero = csel ? (job.col == '0) : (job.col == COL_W'(1));

	assign meta_in = '{valid: q_valid,
		row: rsel ? job.row : job.row - 1'b1,
		col: csel ? job.col : job.col - 1'b1,
		last: last_r && last_c, done: rsel && csel};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ra_q <= 1'b0;
			cb_q <= 1'b0;
		end else if (issue) begin
			if (last_c) begin
				cb_q <= 1'b0;
				ra_q <= last_r ? 1'b0 : 1'b1;
			end else begin
				cb_q <= 1'b1;
			end
		end
	end

	// Stage 1: pick the window pixel for each tap, padding to zero, and multiply.
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int m = 0; m < 3; m++) begin
				for (int k = 0; k < 3; k++) begin
					logic [2:0]              wr, wc;
					logic signed [PIX_W-1:0] px, tp;
					wr = 3'(m) + 3'(rsel);
					wc = 3'(k) + 3'(csel);
					tp = $signed(coef.taps[m][k*PIX_W +: PIX_W]);
					if (wr > 3'd2 || wc > 3'd2 || (r_zero && m == 0) || (c_zero && k == 0)) begin
						px = '0;
					end else begin
						px = $signed(job.win[wr[1:0]*3 + wc[1:0]]);
					end
					prod_s1[m*3+k] <= px * tp;
				end
			end
		end
	end

	always_comb begin
		acc_sum = '0;
		for (int t = 0; t < TAP_COUNT; t++) begin
			acc_sum = acc_sum + ACC_W'(prod_s1[t]);
		end
	end

	// Stages 2 to 5: sum, two partial products of the scale, recombine, shift, add the bias and clamp.
	always_ff @(posedge clk) begin
		if (adv) begin
			acc_s2   <= acc_sum;
			pp_lo_s3 <= acc_s2 * $signed({1'b0, coef.mult[HALF_W-1:0]});
			pp_hi_s3 <= acc_s2 * $signed({1'b0, coef.mult[MULT_W-1:HALF_W]});
			full_s4  <= FULL_W'(pp_lo_s3) + (FULL_W'(pp_hi_s3) <<< HALF_W);
		end
	end

	assign shifted = full_s4 >>> coef.shift;
	assign biased  = SUM_W'(shifted) + SUM_W'($signed(coef.bias));

	always_comb begin
		if (biased > $signed(SUM_W'({1'b0, {(VAL_W-1){1'b1}}}))) begin
			sat = {1'b0, {(VAL_W-1){1'b1}}};
		end else if (biased < -$signed(SUM_W'({1'b1, {(VAL_W-1){1'b0}}}))) begin
			sat = {1'b1, {(VAL_W-1){1'b0}}};
		end else begin
			sat = biased[VAL_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			meta_s1   <= '0;
			meta_s2   <= '0;
			meta_s3   <= '0;
			meta_s4   <= '0;
			out_valid <= 1'b0;
		end else if (adv) begin
			meta_s1   <= meta_in;
			meta_s2   <= meta_s1;
			meta_s3   <= meta_s2;
			meta_s4   <= meta_s3;
			out_valid <= meta_s4.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			value       <= sat;
			out_row     <= meta_s4.row;
			out_col     <= meta_s4.col;
			last_in_run <= meta_s4.last;
			plane_done  <= meta_s4.done;
		end
	end

endmodule
`default_nettype wire

@@ src/depthwise_conv3x3_stream.sv @@
// A pixel is taken in the idle state and classified in the update state, where a full
// queue can stall it; each result then passes five pipeline stages. A new pixel is
// taken only after the last one's line store read and write-back; results leave at
// one per cycle while out_ready holds, up to four per pixel.
// Reset: asynchronous, active low; clears position, window, queue, pipeline valids and
// loads the configuration defaults, then zeroes every entry of both line stores.
`default_nettype none
module depthwise_conv3x3_stream
	import dwc_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic [PIX_W-1:0]      pixel,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic [VAL_W-1:0]           value,
	output logic [ROW_W-1:0]           out_row,
	output logic [COL_W-1:0]           out_col,
	output logic                       last_in_run,
	output logic                       plane_done
);

	logic [2:0][ROWTAP_W-1:0] taps_q;
	logic [MULT_W-1:0]        mult_q;
	logic [SHIFT_W-1:0]       shift_q;
	logic [VAL_W-1:0]         bias_q;
	logic [DIM_W-1:0]         width_q, height_q;
	logic [COL_W-1:0]         wm1;
	logic [ROW_W-1:0]         hm1;
	coef_t                    coef;
	job_t                     push_job, head;
	logic                     push, q_full, pop, q_valid;

	// Configuration registers; the user must write them only while the block is idle; not enforced.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			taps_q   <= '0;
			mult_q   <= MULT_W'(65536);
			shift_q  <= '0;
			bias_q   <= '0;
			width_q  <= DIM_W'(1);
			height_q <= DIM_W'(1);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_TAPS_TOP:    taps_q[0] <= cfg_data[ROWTAP_W-1:0];
				REG_TAPS_MIDDLE: taps_q[1] <= cfg_data[ROWTAP_W-1:0];
				REG_TAPS_BOTTOM: taps_q[2] <= cfg_data[ROWTAP_W-1:0];
				REG_SCALE_MULT:  mult_q    <= cfg_data[MULT_W-1:0];
				REG_SCALE_SHIFT: shift_q   <= cfg_data[SHIFT_W-1:0];
				REG_BIAS:        bias_q    <= cfg_data[VAL_W-1:0];
				REG_WIDTH:       width_q   <= cfg_data[DIM_W-1:0];
				REG_HEIGHT:      height_q  <= cfg_data[DIM_W-1:0];
				default: ;
			endcase
		end
	end

	// Effective plane size less one: zero counts as one, oversize clamps to the maximum.
	always_comb begin
		if (width_q == '0) begin
			wm1 = '0;
		end else if (width_q > DIM_W'(MAX_WIDTH)) begin
			wm1 = COL_W'(MAX_WIDTH - 1);
		end else begin
			wm1 = COL_W'(width_q - 1'b1);
		end
		if (height_q == '0) begin
			hm1 = '0;
		end else if (height_q > DIM_W'(MAX_HEIGHT)) begin
			hm1 = ROW_W'(MAX_HEIGHT - 1);
		end else begin
			hm1 = ROW_W'(height_q - 1'b1);
		end
	end

	assign coef = '{taps: taps_q, mult: mult_q, shift: shift_q, bias: bias_q};

	// The front end owns the line stores and window and queues one job per pixel
	// that completes at least one output.
	dwc_front u_front (
		.clk(clk), .arst_n(arst_n), .wm1(wm1), .hm1(hm1),
		.in_valid(in_valid), .in_ready(in_ready), .pixel(pixel),
		.push(push), .push_job(push_job), .q_full(q_full)
	);

	dwc_queue u_queue (
		.clk(clk), .arst_n(arst_n), .push(push), .push_job(push_job), .full(q_full),
		.pop(pop), .not_empty(q_valid), .head(head)
	);

	// The back end expands each job into its outputs and runs the arithmetic pipeline.
	dwc_back u_back (
		.clk(clk), .arst_n(arst_n), .coef(coef), .q_valid(q_valid), .job(head),
		.pop(pop), .out_valid(out_valid), .out_ready(out_ready), .value(value),
		.out_row(out_row), .out_col(out_col), .last_in_run(last_in_run),
		.plane_done(plane_done)
	);

endmodule
`default_nettype wire
